/* design/command_frame_receiver_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the command frame receiver
// Each macro checks one property on the rising edge of clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_RECEIVER_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define CFR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define CFR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`else

`define CFR_ASSERT_IMP(label, ante, cons, msg)
`define CFR_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

/* design/cfr_pkg.sv */
// ----------------------------------------------------------------------------
// cfr_pkg
// Constants and types shared by the command frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

	// Header bytes. Every byte at or above HDR_LOW is a header.
	localparam logic [7:0] HDR_MOTION = 8'hFF;
	localparam logic [7:0] HDR_TURN   = 8'hFE;
	localparam logic [7:0] HDR_DEPTH  = 8'hFD;
	localparam logic [7:0] HDR_POWER  = 8'hFC;
	localparam logic [7:0] HDR_LOW    = 8'hFA;

	// Frame lengths in bytes, header and check byte included.
	localparam logic [2:0] LEN_NONE  = 3'd0;
	localparam logic [2:0] LEN_LONG  = 3'd6;
	localparam logic [2:0] LEN_MID   = 3'd4;
	localparam logic [2:0] LEN_SHORT = 3'd3;

	localparam logic [7:0] SUM_OFFSET = 8'h0F;
	localparam logic [7:0] TOGGLE_ON  = 8'h01;

	// Frame kinds.
	localparam logic [2:0] KIND_MOTION = 3'd0;
	localparam logic [2:0] KIND_TURN   = 3'd1;
	localparam logic [2:0] KIND_DEPTH  = 3'd2;
	localparam logic [2:0] KIND_POWER  = 3'd3;
	localparam logic [2:0] KIND_GRAB   = 3'd4;
	localparam logic [2:0] KIND_MODE   = 3'd5;

	// A checked frame handed from the framer to the command registers.
	typedef struct packed {
		logic       valid;
		logic [2:0] kind;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] b4;
	} frame_t;

endpackage

`default_nettype wire

/* design/cfr_store.sv */
// ----------------------------------------------------------------------------
// cfr_store
// Byte store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/cfr_ctrl.sv */
// ----------------------------------------------------------------------------
// cfr_ctrl
// Framing control: stores each byte, tracks the write index and frame length,
// and at frame end reads the stored bytes back to check header and checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_ctrl #(
	parameter int STORE_DEPTH = 32,
	parameter int AW          = 5
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      rx_byte,
	output logic                 mem_we,
	output logic      [AW-1:0]   mem_waddr,
	output logic      [7:0]      mem_wdata,
	output logic                 mem_re,
	output logic      [AW-1:0]   mem_raddr,
	input  wire logic [7:0]      mem_rdata,
	input  wire logic            busy,
	output cfr_pkg::frame_t      frm
);

	import cfr_pkg::*;

	`include "command_frame_receiver_assert.svh"

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] idx_q;
	logic [2:0]    len_q;
	logic [2:0]    ptr_q;
	logic          rd_vld_s1;
	logic [2:0]    rd_pos_s1;
	logic [7:0]    last_q;
	logic [7:0]    head_q;
	logic [7:0]    sum_q;
	logic [7:0]    b1_q;
	logic [7:0]    b2_q;
	logic [7:0]    b3_q;
	logic [7:0]    b4_q;

	logic          accept;
	logic          is_hdr;
	logic [2:0]    hdr_len;
	logic [2:0]    len_nxt;
	logic [AW-1:0] idx_base;
	logic [AW:0]   idx_inc;
	logic [AW-1:0] idx_nxt;
	logic          check_go;
	logic [2:0]    ptr_last;
	logic          frame_ok;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_hdr   = (rx_byte >= HDR_LOW);

	always_comb begin
		if (rx_byte == HDR_MOTION || rx_byte == HDR_TURN) begin
			hdr_len = LEN_LONG;
		end else if (rx_byte == HDR_DEPTH) begin
			hdr_len = LEN_MID;
		end else begin
			hdr_len = LEN_SHORT;
		end
	end

	// A header restarts framing at slot zero.
	assign len_nxt  = is_hdr ? hdr_len : len_q;
	assign idx_base = is_hdr ? '0 : idx_q;
	assign idx_inc  = {1'b0, idx_base} + (AW+1)'(1);
	assign idx_nxt  = (idx_inc >= (AW+1)'(STORE_DEPTH)) ? '0 : idx_inc[AW-1:0];
	assign check_go = (idx_nxt == AW'(len_nxt)) && (len_nxt != LEN_NONE);

	assign mem_we    = accept;
	assign mem_waddr = idx_base;
	assign mem_wdata = rx_byte;
	assign mem_re    = (state_q == ST_READ);
	assign mem_raddr = AW'(ptr_q);

	// Slots zero to length minus two are read; the last byte is kept aside.
	assign ptr_last = len_q - 3'd2;

	assign frame_ok = (head_q >= HDR_LOW) &&
		((sum_q == last_q) || ((last_q >= SUM_OFFSET) && (sum_q == last_q - SUM_OFFSET)));

	always_comb begin
		frm.valid = (state_q == ST_DONE) && frame_ok && !busy;
		frm.kind  = ~head_q[2:0];
		frm.b1    = b1_q;
		frm.b2    = b2_q;
		frm.b3    = b3_q;
		frm.b4    = b4_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			len_q     <= LEN_NONE;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			rd_pos_s1 <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_READ);
			rd_pos_s1 <= ptr_q;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= idx_nxt;
						len_q <= len_nxt;
						if (check_go) begin
							ptr_q   <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (ptr_q == ptr_last) begin
						state_q <= ST_DRAIN;
					end else begin
						ptr_q <= ptr_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!frame_ok) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else if (!busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Read data comes back in the cycle after its address; slot zero is the header.
	always_ff @(posedge clk) begin
		if (accept && check_go) begin
			last_q <= rx_byte;
			sum_q  <= '0;
		end else if (rd_vld_s1) begin
			if (rd_pos_s1 != 3'd0) begin
				sum_q <= sum_q + mem_rdata;
			end
			case (rd_pos_s1)
				3'd0:    head_q <= mem_rdata;
				3'd1:    b1_q   <= mem_rdata;
				3'd2:    b2_q   <= mem_rdata;
				3'd3:    b3_q   <= mem_rdata;
				3'd4:    b4_q   <= mem_rdata;
				default: head_q <= head_q;
			endcase
		end
	end

	`CFR_ASSERT_IMP(a_rd_in_seq, rd_vld_s1, (state_q == ST_READ) || (state_q == ST_DRAIN), "read data outside the check sequence")
	`CFR_ASSERT_NXT(a_check_start, accept && check_go, (state_q == ST_READ) && (ptr_q == 3'd0), "frame check did not start at slot zero")
	`CFR_ASSERT_IMP(a_idx_range, 1'b1, int'(idx_q) < STORE_DEPTH, "write index beyond store depth")

endmodule

`default_nettype wire

/* design/cfr_cmd.sv */
// ----------------------------------------------------------------------------
// cfr_cmd
// Command registers and result register: applies a checked frame and holds
// the result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_cmd (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  cfr_pkg::frame_t         frm,
	output logic                    busy,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic        [2:0]       frame_kind,
	output logic signed [15:0]      speed_x,
	output logic signed [15:0]      speed_y,
	output logic signed [15:0]      turn_rate,
	output logic signed [15:0]      depth_target,
	output logic                    power_on,
	output logic                    grab_on,
	output logic                    mode_flag
);

	import cfr_pkg::*;

	`include "command_frame_receiver_assert.svh"

	logic              out_valid_q;
	logic [2:0]        kind_q;
	logic signed [15:0] speed_x_q;
	logic signed [15:0] speed_y_q;
	logic signed [15:0] turn_q;
	logic signed [15:0] depth_q;
	logic [2:0]        flags_q;
	logic              toggle;

	// The held commands are the result, so a new frame waits until it is taken.
	assign busy   = out_valid_q && !out_ready;
	assign toggle = (frm.b1 == TOGGLE_ON);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kind_q      <= KIND_MOTION;
			speed_x_q   <= '0;
			speed_y_q   <= '0;
			turn_q      <= '0;
			depth_q     <= '0;
			flags_q     <= '0;
		end else begin
			if (frm.valid) begin
				out_valid_q <= 1'b1;
				kind_q      <= frm.kind;
				case (frm.kind)
					KIND_MOTION: begin
						speed_x_q <= {frm.b1, frm.b2};
						speed_y_q <= {frm.b3, frm.b4};
					end
					KIND_TURN:  turn_q  <= {frm.b1, frm.b2};
					KIND_DEPTH: depth_q <= {frm.b1, frm.b2};
					KIND_POWER: flags_q[0] <= flags_q[0] ^ toggle;
					KIND_GRAB:  flags_q[1] <= flags_q[1] ^ toggle;
					KIND_MODE:  flags_q[2] <= flags_q[2] ^ toggle;
					default:    flags_q <= flags_q;
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_kind   = kind_q;
	assign speed_x      = speed_x_q;
	assign speed_y      = speed_y_q;
	assign turn_rate    = turn_q;
	assign depth_target = depth_q;
	assign power_on     = flags_q[0];
	assign grab_on      = flags_q[1];
	assign mode_flag    = flags_q[2];

	`CFR_ASSERT_NXT(a_frame_shown, frm.valid, out_valid_q, "checked frame not presented")
	`CFR_ASSERT_NXT(a_flags_hold, !frm.valid, $stable(flags_q), "flags changed without a frame")
	`CFR_ASSERT_IMP(a_no_overrun, frm.valid, !busy, "frame applied over a pending result")

endmodule

`default_nettype wire

/* design/command_frame_receiver.sv */
// ----------------------------------------------------------------------------
// command_frame_receiver
// Receives serial command bytes, frames and checks them, and reports the
// command state after every valid frame.
// ----------------------------------------------------------------------------
// A byte that does not complete a frame is taken as soon as it is offered,
// and a byte is taken every cycle while that holds. The byte that completes
// a frame of length L (6 for motion and turn, 4 for depth, 3 for toggles)
// starts a check that reads stored slots 0 to L-2 one per cycle through the
// store's single read port, then passes the drain and done states before the
// next byte is accepted, and stays there while the previous result is still
// waiting to be taken. A result holds every command field and flag; frames
// that fail the header or checksum test produce no result and restart framing.
`default_nettype none

module command_frame_receiver #(
	parameter int STORE_DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic        [2:0]       frame_kind,
	output logic signed [15:0]      speed_x,
	output logic signed [15:0]      speed_y,
	output logic signed [15:0]      turn_rate,
	output logic signed [15:0]      depth_target,
	output logic                    power_on,
	output logic                    grab_on,
	output logic                    mode_flag
);

	import cfr_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic          busy;
	frame_t        frm;

	cfr_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cfr_ctrl #(
		.STORE_DEPTH (STORE_DEPTH),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.busy      (busy),
		.frm       (frm)
	);

	cfr_cmd u_cmd (
		.clk          (clk),
		.arst_n       (arst_n),
		.frm          (frm),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_kind   (frame_kind),
		.speed_x      (speed_x),
		.speed_y      (speed_y),
		.turn_rate    (turn_rate),
		.depth_target (depth_target),
		.power_on     (power_on),
		.grab_on      (grab_on),
		.mode_flag    (mode_flag)
	);

endmodule

`default_nettype wire

/* test/tb_command_frame_receiver.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_frame_receiver
// Streams serial bytes into the command frame receiver: a long headerless
// run, directed frames of every kind, random well-formed and broken frames,
// a long output stall and a drained pause. A byte-level model of the framer
// predicts each command report, and every report is checked field by field.
// ----------------------------------------------------------------------------

module tb_command_frame_receiver;
	import cfr_pkg::*;

	localparam int         STORE_DEPTH   = 32;
	localparam int         QUIET_LIMIT   = 2000;
	localparam int         SETTLE_CYCLES = 12;
	localparam logic [7:0] HDR_GRAB      = 8'hFB;
	localparam logic [7:0] HDR_MODE      = HDR_LOW;
	localparam logic [7:0] PAYLOAD_MAX   = 8'hF9;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] speed_x;
		logic [15:0] speed_y;
		logic [15:0] turn_rate;
		logic [15:0] depth_target;
		logic        power_on;
		logic        grab_on;
		logic        mode_flag;
	} command_report_t;

	typedef enum int {CHK_PLAIN, CHK_OFFSET, CHK_BROKEN} check_style_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         frame_kind;
	logic signed [15:0] speed_x;
	logic signed [15:0] speed_y;
	logic signed [15:0] turn_rate;
	logic signed [15:0] depth_target;
	logic               power_on;
	logic               grab_on;
	logic               mode_flag;

	// Framer model state.
	logic [7:0]  shadow_store [STORE_DEPTH];
	int unsigned shadow_index;
	logic [2:0]  shadow_length;
	logic [15:0] held_speed_x;
	logic [15:0] held_speed_y;
	logic [15:0] held_turn;
	logic [15:0] held_depth;
	logic [2:0]  held_flags;

	command_report_t pending_reports [$];
	command_report_t wanted;
	command_report_t fresh;
	int unsigned     bytes_taken;
	int unsigned     error_count;
	int unsigned     quiet_cycles;
	int unsigned     rx_hold_left;
	int unsigned     rx_stall_left;
	bit              tx_gaps_on;
	bit              rx_stalls_on;

	command_frame_receiver #(
		.STORE_DEPTH(STORE_DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.frame_kind  (frame_kind),
		.speed_x     (speed_x),
		.speed_y     (speed_y),
		.turn_rate   (turn_rate),
		.depth_target(depth_target),
		.power_on    (power_on),
		.grab_on     (grab_on),
		.mode_flag   (mode_flag)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Advances the framer by one byte; returns 1 when the byte completes a good frame.
	function automatic bit absorb_byte(input logic [7:0] b, output command_report_t rep);
		logic [7:0] head;
		logic [7:0] last;
		logic [7:0] sum;
		logic [2:0] kind;
		rep = '0;
		if (b == HDR_MOTION || b == HDR_TURN) begin
			shadow_index  = 0;
			shadow_length = LEN_LONG;
		end else if (b == HDR_DEPTH) begin
			shadow_index  = 0;
			shadow_length = LEN_MID;
		end else if (b >= HDR_LOW) begin
			shadow_index  = 0;
			shadow_length = LEN_SHORT;
		end
		shadow_store[shadow_index] = b;
		shadow_index = (shadow_index + 1) % STORE_DEPTH;
		if (shadow_index != shadow_length)
			return 1'b0;
		head = shadow_store[0];
		if (head < HDR_LOW || shadow_length < 2) begin
			shadow_index = 0;
			return 1'b0;
		end
		sum = '0;
		for (int i = 1; i + 1 < shadow_length; i++)
			sum += shadow_store[i];
		last = shadow_store[shadow_length - 1];
		// The offset form of the check byte only counts when it does not wrap.
		if (sum != last && !(last >= SUM_OFFSET && sum == 8'(last - SUM_OFFSET))) begin
			shadow_index = 0;
			return 1'b0;
		end
		kind = 3'(HDR_MOTION - head);
		case (kind)
			KIND_MOTION: begin
				held_speed_x = {shadow_store[1], shadow_store[2]};
				held_speed_y = {shadow_store[3], shadow_store[4]};
			end
			KIND_TURN:  held_turn  = {shadow_store[1], shadow_store[2]};
			KIND_DEPTH: held_depth = {shadow_store[1], shadow_store[2]};
			KIND_POWER: if (shadow_store[1] == TOGGLE_ON) held_flags[0] = ~held_flags[0];
			KIND_GRAB:  if (shadow_store[1] == TOGGLE_ON) held_flags[1] = ~held_flags[1];
			default:    if (shadow_store[1] == TOGGLE_ON) held_flags[2] = ~held_flags[2];
		endcase
		rep.kind         = kind;
		rep.speed_x      = held_speed_x;
		rep.speed_y      = held_speed_y;
		rep.turn_rate    = held_turn;
		rep.depth_target = held_depth;
		rep.power_on     = held_flags[0];
		rep.grab_on      = held_flags[1];
		rep.mode_flag    = held_flags[2];
		return 1'b1;
	endfunction

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Report checker and request monitor share one process, so the model sees
	// requests in the order the block takes them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					$display("%0t: report expected none, got kind %0d", $time, frame_kind);
					error_count++;
				end else begin
					wanted = pending_reports.pop_front();
					compare_field("frame_kind", 16'(wanted.kind), 16'(frame_kind));
					compare_field("speed_x", wanted.speed_x, speed_x);
					compare_field("speed_y", wanted.speed_y, speed_y);
					compare_field("turn_rate", wanted.turn_rate, turn_rate);
					compare_field("depth_target", wanted.depth_target, depth_target);
					compare_field("power_on", 16'(wanted.power_on), 16'(power_on));
					compare_field("grab_on", 16'(wanted.grab_on), 16'(grab_on));
					compare_field("mode_flag", 16'(wanted.mode_flag), 16'(mode_flag));
				end
			end
			if (in_valid && in_ready) begin
				bytes_taken++;
				if (absorb_byte(rx_byte, fresh))
					pending_reports.push_back(fresh);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Report side: a long hold-off takes precedence over the short random stalls.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				out_ready <= 1'b0;
			end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
				rx_stall_left = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned target;
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		target = bytes_taken + 1;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(negedge clk);
		while (bytes_taken != target);
	endtask

	task automatic send_frame(input logic [7:0] head, input logic [31:0] body,
			input check_style_t style);
		int         n;
		logic [7:0] sum;
		n = (head == HDR_MOTION || head == HDR_TURN) ? 4 : (head == HDR_DEPTH) ? 2 : 1;
		sum = '0;
		send_byte(head);
		for (int i = 0; i < n; i++) begin
			send_byte(body[31 - 8*i -: 8]);
			sum += body[31 - 8*i -: 8];
		end
		case (style)
			CHK_PLAIN:  send_byte(sum);
			CHK_OFFSET: send_byte(sum + SUM_OFFSET);
			default:    send_byte(sum + 8'($urandom_range(1, 14)));
		endcase
	endtask

	task automatic send_random_frame();
		logic [7:0]  head;
		logic [31:0] body;
		int unsigned roll;
		head = HDR_MOTION - 8'($urandom_range(0, 5));
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 9))
				0:       body[8*i +: 8] = 8'h00;
				1:       body[8*i +: 8] = 8'h7F;
				2:       body[8*i +: 8] = 8'h80;
				3:       body[8*i +: 8] = PAYLOAD_MAX;
				default: body[8*i +: 8] = 8'($urandom_range(0, PAYLOAD_MAX));
			endcase
		end
		if (head <= HDR_POWER && $urandom_range(0, 1) == 1)
			body[31:24] = TOGGLE_ON;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			send_frame(head, body, CHK_PLAIN);
		else if (roll < 80)
			send_frame(head, body, CHK_OFFSET);
		else
			send_frame(head, body, CHK_BROKEN);
	endtask

	task automatic wait_for_reports();
		while (pending_reports.size() != 0)
			@(negedge clk);
		// A failing frame produces no report but still occupies the checker.
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// With no header since reset the index wraps and no frame check starts.
	task automatic test_idle_line(input int count);
		repeat (count) send_byte(8'($urandom_range(0, PAYLOAD_MAX)));
	endtask

	task automatic test_directed_frames();
		// Most negative speed_x; the payload sum wraps to a zero check byte.
		send_frame(HDR_MOTION, 32'h8000_7F01, CHK_PLAIN);
		send_frame(HDR_TURN, 32'h7FF9_1234, CHK_OFFSET);
		send_frame(HDR_DEPTH, 32'hF900_0000, CHK_PLAIN);
		send_frame(HDR_POWER, {TOGGLE_ON, 24'h0}, CHK_PLAIN);
		// A toggle without the on byte is still a good frame but flips nothing.
		send_frame(HDR_GRAB, 32'h0200_0000, CHK_OFFSET);
		send_frame(HDR_MODE, {TOGGLE_ON, 24'h0}, CHK_OFFSET);
		// The offset check byte wraps below 0x0F here, so the frame is rejected.
		send_frame(HDR_POWER, 32'hF500_0000, CHK_OFFSET);
	endtask

	task automatic test_random_frames(input int frames);
		for (int f = 0; f < frames; f++) begin
			if (f % 10 == 0) begin
				tx_gaps_on   = $urandom_range(0, 1);
				rx_stalls_on = $urandom_range(0, 1);
			end
			send_random_frame();
			// Trailing bytes land after a good frame, since the index is not cleared.
			if ($urandom_range(0, 7) == 0)
				send_byte(8'($urandom_range(0, PAYLOAD_MAX)));
		end
	endtask

	task automatic test_backpressure();
		tx_gaps_on   = 0;
		rx_hold_left = 80;
		repeat (10) send_frame(HDR_MOTION, $urandom & 32'h7F7F7F7F, CHK_PLAIN);
		tx_gaps_on = 1;
	endtask

	task automatic test_drain_pause();
		repeat (3) send_random_frame();
		in_valid <= 1'b0;
		wait_for_reports();
		repeat (3) send_random_frame();
	endtask

	task automatic test_noise(input int count);
		repeat (count) begin
			case ($urandom_range(0, 3))
				0: send_byte(8'($urandom_range(0, 255)));
				1: send_byte(HDR_MOTION - 8'($urandom_range(0, 5)));
				2: begin
					// A frame cut short by the next header.
					send_byte(HDR_MOTION - 8'($urandom_range(0, 5)));
					send_byte(8'($urandom_range(0, PAYLOAD_MAX)));
				end
				default: send_random_frame();
			endcase
		end
	endtask

	task automatic test_steady_stream(input int frames);
		tx_gaps_on   = 0;
		rx_stalls_on = 0;
		repeat (frames) send_random_frame();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		rx_byte       = '0;
		tx_gaps_on    = 1;
		rx_stalls_on  = 1;
		rx_hold_left  = 0;
		rx_stall_left = 0;
		bytes_taken   = 0;
		error_count   = 0;
		foreach (shadow_store[i])
			shadow_store[i] = '0;
		shadow_index  = 0;
		shadow_length = LEN_NONE;
		held_speed_x  = '0;
		held_speed_y  = '0;
		held_turn     = '0;
		held_depth    = '0;
		held_flags    = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_idle_line(40);
		test_directed_frames();
		test_random_frames(40);
		test_backpressure();
		test_drain_pause();
		test_noise(30);
		test_steady_stream(8);
		in_valid <= 1'b0;
		wait_for_reports();
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
